// ===== rtl/core/zpbm_pkg.sv =====
// Package for the zero-padded box mean filter.
// Holds payload structs, register indexes, FSM state type and ctrl/datapath links.
package zpbm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_HEIGHT     = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mean_pixel;
    logic       last_of_frame;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_TAIL,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic write;
    logic acc_start;
    logic acc_step;
    logic div_start;
    logic div_step;
    logic load;
    logic cfg_we;
  } cmd_t;

  typedef struct packed {
    logic p_zero;
    logic before_delay;
    logic acc_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/zero_padded_box_mean_filter.sv =====
// Top level of the zero-padded box mean filter.
// Depends on zpbm_pkg, zpbm_ctrl, zpbm_datapath (which holds zpbm_ram).
//
// Usage:
//  - in_valid/in_ready carry one pixel (or a flush tick) per beat, raster order.
//  - out_valid/out_ready carry one window mean per beat, raster order; the
//    final result of a frame has last_of_frame set. After the last pixel the
//    source sends flush beats until that result appears.
//  - cfg_valid/cfg_ready write window_size (0), image_width (1) or
//    image_height (2); any write restarts the frame. Write only when idle.
//  - The first floor(ws/2)*width + floor(ws/2) beats give no result.
//  - An item that gives a result passes through accept (S_IDLE), the window
//    sweep (S_ACC, one history RAM read per in-image sample), tail (S_TAIL),
//    the bit-serial divide (S_DIV) and load (S_LOAD), which waits for the
//    output register to free. Items giving no result leave the FSM in S_IDLE.
//  - The output register holds a result while the receiver stalls; the next
//    item is accepted meanwhile, but its result waits for the register to free.
//  - Reset (rst_n low, synchronous) restores window_size 3 and 1024x1024 and
//    returns to the start of a frame; the history RAM needs no clearing.
module zero_padded_box_mean_filter import zpbm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  zpbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_flush  (in_data.flush),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  zpbm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/zpbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/zpbm_ctrl.sv =====
// Controller FSM for the box mean filter: sequences accept, window sweep,
// division and result load. Depends on zpbm_pkg.
module zpbm_ctrl import zpbm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_flush,
  output logic in_ready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !(in_flush && sts.p_zero) && !sts.before_delay) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sts.acc_last) state_nxt = S_TAIL;
      end
      S_TAIL: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.write     = accept && !(in_flush && sts.p_zero);
    cmd.acc_start = cmd.write && !sts.before_delay;
    cmd.acc_step  = (state_r == S_ACC);
    cmd.div_start = (state_r == S_TAIL);
    cmd.div_step  = (state_r == S_DIV);
    cmd.load      = (state_r == S_LOAD) && sts.out_free;
    cmd.cfg_we    = (state_r == S_IDLE) && cfg_valid;
  end

endmodule

// ===== rtl/core/zpbm_datapath.sv =====
// Datapath: config registers, stream/result counters, history RAM, window
// accumulator, serial divider and output register. Depends on zpbm_pkg, zpbm_ram.
module zpbm_datapath import zpbm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  in_item_t              in_data,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int AW    = $clog2(MAX_WIDTH * (MAX_WINDOW - 1) + MAX_WINDOW);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = COL_W + 1;
  localparam int ROW_W = 12;
  localparam int SW    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int DV_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(SUM_W + 1);

  // configuration
  logic [2:0]            ws_r;
  logic [CFG_DATA_W-1:0] iw_r, ih_r;
  logic [WIN_W-1:0]      win, h;
  logic [WW-1:0]         w;
  logic [ROW_W-1:0]      ht;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= 3'd3;
      iw_r <= CFG_DATA_W'(1024);
      ih_r <= CFG_DATA_W'(1024);
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  ws_r <= cfg_data[2:0];
        REG_IMAGE_WIDTH:  iw_r <= cfg_data;
        REG_IMAGE_HEIGHT: ih_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ws_r == '0)                   win = WIN_W'(1);
    else if (32'(ws_r) > MAX_WINDOW)  win = WIN_W'(MAX_WINDOW);
    else                              win = WIN_W'(ws_r);
    if (iw_r == '0)                   w = WW'(1);
    else if (32'(iw_r) > MAX_WIDTH)   w = WW'(MAX_WIDTH);
    else                              w = WW'(iw_r);
    if (ih_r == '0)                   ht = ROW_W'(1);
    else if (32'(ih_r) > MAX_HEIGHT)  ht = ROW_W'(MAX_HEIGHT);
    else                              ht = ROW_W'(ih_r);
  end
  assign h = win >> 1;

  // input stream position
  logic [COL_W-1:0] in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [AW-1:0]    p_addr_r;
  logic             in_pix;
  // beats written so far, held once the first result is due
  logic [AW-1:0]    seen_r;
  logic [AW-1:0]    dly;

  // result position
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic [AW-1:0]    k_addr_r;
  logic             is_last;

  assign in_pix  = (in_row_r < ht);
  assign is_last = (out_row_r == ht - ROW_W'(1)) && ({1'b0, out_col_r} == w - WW'(1));
  assign dly     = AW'(h * w) + AW'(h);

  assign sts.p_zero       = (in_col_r == '0) && (in_row_r == '0);
  assign sts.before_delay = (seen_r < dly);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cfg_we || (cmd.load && is_last)) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      p_addr_r  <= '0;
      seen_r    <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      k_addr_r  <= '0;
    end else begin
      if (cmd.write) begin
        p_addr_r <= p_addr_r + AW'(1);
        if (sts.before_delay) begin
          seen_r <= seen_r + AW'(1);
        end
        if ({1'b0, in_col_r} + WW'(1) >= w) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
      if (cmd.load) begin
        k_addr_r <= k_addr_r + AW'(1);
        if ({1'b0, out_col_r} + WW'(1) >= w) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + ROW_W'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
    end
  end

  // window sweep: i over rows, j over columns, addr follows the sample
  logic [WIN_W-1:0] i_r, j_r;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    hw;
  logic signed [SW-1:0] rr, cc;
  logic             inb, rd_v_r;
  logic [7:0]       rd_data;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  assign hw  = AW'(h * w);
  assign rr  = $signed(SW'(out_row_r)) - $signed(SW'(h)) + $signed(SW'(i_r));
  assign cc  = $signed(SW'(out_col_r)) - $signed(SW'(h)) + $signed(SW'(j_r));
  assign inb = cmd.acc_step && (rr >= 0) && (rr < $signed(SW'(ht))) &&
               (cc >= 0) && (cc < $signed(SW'(w)));
  assign sts.acc_last = (i_r == win - WIN_W'(1)) && (j_r == win - WIN_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.acc_start) begin
      i_r    <= '0;
      j_r    <= '0;
      addr_r <= k_addr_r - hw - AW'(h);
    end else if (cmd.acc_step) begin
      if (j_r == win - WIN_W'(1)) begin
        j_r    <= '0;
        i_r    <= i_r + WIN_W'(1);
        addr_r <= addr_r + AW'(w) - AW'(win) + AW'(1);
      end else begin
        j_r    <= j_r + WIN_W'(1);
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= inb;
    end
  end

  assign sum_nxt = sum_r + (rd_v_r ? SUM_W'(rd_data) : '0);

  always_ff @(posedge clk) begin
    if (cmd.acc_start) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  zpbm_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (p_addr_r),
    .wdata ((in_pix && !in_data.flush) ? in_data.pixel : 8'd0),
    .re    (inb),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  // restoring divider, one quotient bit a cycle
  logic [DV_W-1:0]  dvs;
  logic [DV_W-1:0]  rem_r;
  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DV_W:0]    trial;
  logic             ge;

  assign dvs   = DV_W'(win * win);
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign sts.div_done = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= sum_nxt;
      cnt_r <= CNT_W'(SUM_W);
    end else if (cmd.div_step && cnt_r != '0) begin
      rem_r <= ge ? DV_W'(trial - {1'b0, dvs}) : DV_W'(trial);
      quo_r <= {quo_r[SUM_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.mean_pixel    <= quo_r[7:0];
      out_data_r.last_of_frame <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
